### design/mclr_pkg.sv
// ----------------------------------------------------------------------------
// Motion command log package
// Shared types, constants and pin/inverse decode for the motion command log.
// ----------------------------------------------------------------------------
`default_nettype none

package mclr_pkg;

  // Log geometry and result limits.
  localparam int LOG_DEPTH   = 16;
  localparam int IDX_W       = $clog2(LOG_DEPTH);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int OP_W    = 3;
  localparam int DUR_W   = 16;
  localparam int PAUSE_W = 9;
  localparam int PINS_W  = 4;

  // Stream widths.
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  localparam logic [PAUSE_W-1:0] REWIND_PAUSE_MS = PAUSE_W'(500);

  // Command opcodes.
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_FORWARD = 3'd1;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd2;
  localparam logic [OP_W-1:0] OP_LEFT    = 3'd3;
  localparam logic [OP_W-1:0] OP_RIGHT   = 3'd4;
  localparam logic [OP_W-1:0] OP_REWIND  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DUR_W-1:0] dur;
  } log_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the accepted input beat
    logic push_motion;  // log the command and load its result
    logic start_walk;   // set up a rewind walk at the newest slot
    logic rd_issue;     // read the log at the walk index
    logic take_entry;   // move the read entry into the pending result
    logic push_pend;    // load the pending result into the output register
    logic push_last;    // flag for the pushed pending result
    logic clear_newest; // mark the newest slot empty
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_motion;
    logic is_rewind;
    logic entry_valid;
    logic cnt_full;
    logic lap_done;
    logic pend_valid;
    logic out_free;
  } ctrl_sts_t;

  // Bridge pins, bit 3 down to 0: a_in1 a_in2 b_in1 b_in2.
  function automatic logic [PINS_W-1:0] pins_of(input logic [OP_W-1:0] op);
    logic [PINS_W-1:0] p;
    p = 4'h0;
    case (op)
      OP_FORWARD: p = 4'h9;
      OP_REVERSE: p = 4'h6;
      OP_LEFT:    p = 4'hA;
      OP_RIGHT:   p = 4'h5;
      default:    p = 4'h0;
    endcase
    return p;
  endfunction

  function automatic logic [OP_W-1:0] inverse_of(input logic [OP_W-1:0] op);
    logic [OP_W-1:0] r;
    r = OP_NONE;
    case (op)
      OP_FORWARD: r = OP_REVERSE;
      OP_REVERSE: r = OP_FORWARD;
      OP_LEFT:    r = OP_RIGHT;
      OP_RIGHT:   r = OP_LEFT;
      default:    r = OP_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/mclr_ctrl.sv
// ----------------------------------------------------------------------------
// Motion command log controller
// Sequences command dispatch and the rewind walk over the log.
// ----------------------------------------------------------------------------
`default_nettype none

module mclr_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  mclr_pkg::ctrl_sts_t   sts,
  output mclr_pkg::ctrl_cmd_t   cmd
);
  import mclr_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_motion) begin
          if (sts.out_free) begin
            cmd.push_motion = 1'b1;
            state_next      = ST_IDLE;
          end
        end else if (sts.is_rewind) begin
          cmd.start_walk = 1'b1;
          state_next     = ST_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts.entry_valid || sts.cnt_full) begin
          // The walk ends here; flush what is pending as the last beat.
          if (!sts.pend_valid) begin
            cmd.clear_newest = 1'b1;
            state_next       = ST_IDLE;
          end else if (sts.out_free) begin
            cmd.push_pend    = 1'b1;
            cmd.push_last    = 1'b1;
            cmd.clear_newest = 1'b1;
            state_next       = ST_IDLE;
          end
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.push_pend  = sts.pend_valid;
          cmd.take_entry = 1'b1;
          state_next     = sts.lap_done ? ST_FINAL : ST_READ;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.push_pend    = 1'b1;
          cmd.push_last    = 1'b1;
          cmd.clear_newest = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/mclr_datapath.sv
// ----------------------------------------------------------------------------
// Motion command log datapath
// Holds the ring log, walk index, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mclr_datapath (
  input  wire                              clk,
  input  wire                              rst,
  input  wire [mclr_pkg::OP_W-1:0]         in_op,
  input  wire [mclr_pkg::DUR_W-1:0]        in_dur,
  input  mclr_pkg::ctrl_cmd_t              cmd,
  output mclr_pkg::ctrl_sts_t              sts,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [mclr_pkg::PINS_W-1:0]      out_pins,
  output logic [mclr_pkg::DUR_W-1:0]       out_hold,
  output logic [mclr_pkg::PAUSE_W-1:0]     out_pause,
  output logic                             out_last
);
  import mclr_pkg::*;

  // Log storage; an entry whose valid bit is clear reads as none.
  log_entry_t           log_mem [LOG_DEPTH];
  logic [LOG_DEPTH-1:0] log_vld;

  logic [OP_W-1:0]  cmd_op;
  logic [DUR_W-1:0] cmd_dur;
  logic [IDX_W-1:0] newest;
  logic [IDX_W-1:0] newest_inc;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_dec;
  logic [CNT_W-1:0] cnt;
  log_entry_t       rd_entry;
  logic             rd_vld;
  logic [OP_W-1:0]  pend_op;
  logic [DUR_W-1:0] pend_dur;
  logic             pend_valid;

  // Ring index arithmetic.
  assign newest_inc = (newest == IDX_W'(LOG_DEPTH - 1)) ? '0 : newest + 1'b1;
  assign idx_dec    = (idx == '0) ? IDX_W'(LOG_DEPTH - 1) : idx - 1'b1;

  // Status toward the controller.
  always_comb begin
    sts.is_motion   = (cmd_op == OP_FORWARD) || (cmd_op == OP_REVERSE) ||
                      (cmd_op == OP_LEFT) || (cmd_op == OP_RIGHT);
    sts.is_rewind   = (cmd_op == OP_REWIND);
    sts.entry_valid = rd_vld;
    sts.cnt_full    = (cnt >= CNT_W'(MAX_RESULTS));
    sts.lap_done    = (idx_dec == newest);
    sts.pend_valid  = pend_valid;
    sts.out_free    = !out_valid || out_ready;
  end

  // Captured command beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_op  <= in_op;
      cmd_dur <= in_dur;
    end
  end

  // Log memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.push_motion) begin
      log_mem[newest_inc] <= '{op: cmd_op, dur: cmd_dur};
    end
    if (cmd.rd_issue) begin
      rd_entry <= log_mem[idx];
    end
  end

  // Valid bits, newest slot and the registered valid of the read entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      log_vld <= '0;
      newest  <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (cmd.push_motion) begin
        log_vld[newest_inc] <= 1'b1;
        newest              <= newest_inc;
      end
      if (cmd.clear_newest) begin
        log_vld[newest] <= 1'b0;
      end
      if (cmd.rd_issue) begin
        rd_vld <= log_vld[idx];
      end
    end
  end

  // Walk index, result count and pending result.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.start_walk) begin
      idx        <= newest;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.take_entry) begin
      idx        <= idx_dec;
      cnt        <= cnt + 1'b1;
      pend_valid <= 1'b1;
    end else if (cmd.push_pend) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_entry) begin
      pend_op  <= inverse_of(rd_entry.op);
      pend_dur <= rd_entry.dur;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_motion || cmd.push_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_motion) begin
      out_pins  <= pins_of(cmd_op);
      out_hold  <= cmd_dur;
      out_pause <= '0;
      out_last  <= 1'b1;
    end else if (cmd.push_pend) begin
      out_pins  <= pins_of(pend_op);
      out_hold  <= pend_dur;
      out_pause <= REWIND_PAUSE_MS;
      out_last  <= cmd.push_last;
    end
  end

endmodule

`default_nettype wire

### design/motion_command_log_with_rewind.sv
// ----------------------------------------------------------------------------
// Motion command log with rewind
// Drive command logger for a two-motor H-bridge with a rewind walk.
// ----------------------------------------------------------------------------
// Takes one command beat at a time. A motion command is logged and loads its
// beat into the output register once that register is free; the controller
// then returns to idle for the next command. A rewind reads the log through
// its single registered read port, passing the READ and EVAL states for each
// entry walked, and gives one beat per entry (up to the log depth); a stalled
// output slows the walk beat for beat. A new command is taken only when the
// previous one has handed over all of its beats to the output register. The
// log resets to empty at once, with no clearing pass.
`default_nettype none

module motion_command_log_with_rewind (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: opcode[2:0], duration_ms[18:3], zero fill.
  input  wire [mclr_pkg::S_DATA_W-1:0]       s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // Fields from bit 0: motor_a_in1, motor_a_in2, motor_b_in1, motor_b_in2,
  // hold_ms[19:4], pause_ms[28:20], zero fill.
  output logic [mclr_pkg::M_DATA_W-1:0]      m_tdata,
  // Carries last_of_run.
  output logic                               m_tlast
);
  import mclr_pkg::*;

  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  logic [PINS_W-1:0]  out_pins;
  logic [DUR_W-1:0]   out_hold;
  logic [PAUSE_W-1:0] out_pause;

  mclr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mclr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_op     (s_tdata[OP_W-1:0]),
    .in_dur    (s_tdata[OP_W+DUR_W-1:OP_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pins  (out_pins),
    .out_hold  (out_hold),
    .out_pause (out_pause),
    .out_last  (m_tlast)
  );

  // Pack the result beat; pin bit 3 is motor_a_in1.
  assign m_tdata = {3'b000, out_pause, out_hold,
                    out_pins[0], out_pins[1], out_pins[2], out_pins[3]};

endmodule

`default_nettype wire

### design/mclr_checker.sv
// ----------------------------------------------------------------------------
// Motion command log port checker
// Checks result beats seen on the top-level ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mclr_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [mclr_pkg::M_DATA_W-1:0]    m_tdata,
  input wire                             m_tlast
);
  import mclr_pkg::*;

  // A stalled beat holds its payload.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // Pause is either zero for a motion or the rewind pause.
  a_pause_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[28:20] == 9'd0) || (m_tdata[28:20] == REWIND_PAUSE_MS))
    else $error("pause out of range");

  // A direct motion result is always the only beat of its command.
  a_motion_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[28:20] == 9'd0) |-> m_tlast)
    else $error("motion result not flagged last");

  // Never drive both inputs of one bridge high, and keep the fill at zero.
  a_bridge_safe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && !(m_tdata[2] && m_tdata[3]) &&
                 (m_tdata[31:29] == 3'b000))
    else $error("bridge shoot-through pattern");

endmodule

bind motion_command_log_with_rewind mclr_checker u_mclr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
